@@ rtl/pva_pkg.sv @@
// Shared types and constants for the potentiometer volume averaging block.
package pva_pkg;

  // Width of the hysteresis register and of the volume result.
  localparam int unsigned HYST_W = 15;
  localparam int unsigned VOL_W  = 8;

  // Largest volume code; larger quotients saturate here.
  localparam logic [VOL_W-1:0] VOL_MAX = 8'hFF;

  // Fill status reported by each queue to the logic that feeds or drains it.
  typedef struct packed {
    logic full;
    logic empty;
    logic room2;
  } pva_fifo_st_t;

endpackage

@@ rtl/pva_ram.sv @@
// Generic single-write, single-read RAM with a registered, read-first output.
module pva_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 30,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read and a write to the same address in one cycle return the old word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ rtl/pva_fifo.sv @@
// Small register-based queue with full, empty and two-slot room status.
module pva_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  pop,
  output logic [WIDTH-1:0]      rdata,
  output pva_pkg::pva_fifo_st_t st
);
  import pva_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  // Status flags come straight from the occupancy count.
  assign st.full  = (count == CNT_W'(DEPTH));
  assign st.empty = (count == '0);
  assign st.room2 = ((int'(count) + 2) <= int'(DEPTH));

  assign do_push = push && !st.full;
  assign do_pop  = pop && !st.empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ rtl/pva_front.sv @@
// Front end: accepts samples, writes the sample ring and fetches the evicted entry.
module pva_front #(
  parameter int unsigned WINDOW      = 30,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [SAMPLE_BITS-1:0]       adc_sample,
  input  pva_pkg::pva_fifo_st_t        mid_st,
  output logic                         mid_push,
  output logic [2*SAMPLE_BITS-1:0]     mid_data
);
  import pva_pkg::*;

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  logic [IDX_W-1:0]       ring_index;
  logic                   filled;
  logic                   accept;
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   s1_filled;
  logic [SAMPLE_BITS-1:0] ram_q;
  logic [SAMPLE_BITS-1:0] old_sample;

  // A beat in flight needs its own slot in the queue as well as the new one.
  assign full   = s1_valid ? !mid_st.room2 : mid_st.full;
  assign accept = push && !full;

  // Ring position and fill flag; entries not yet written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_index <= '0;
      filled     <= 1'b0;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        ring_index <= (ring_index == LAST_IDX) ? '0 : ring_index + 1'b1;
        if (ring_index == LAST_IDX) begin
          filled <= 1'b1;
        end
      end
    end
  end

  // Stage register that waits for the RAM read.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= adc_sample;
      s1_filled <= filled;
    end
  end

  pva_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (ring_index),
    .wdata (adc_sample),
    .re    (accept),
    .raddr (ring_index),
    .rdata (ram_q)
  );

  // Hand the new sample and the evicted one to the back end.
  assign old_sample = s1_filled ? ram_q : '0;
  assign mid_push   = s1_valid;
  assign mid_data   = {s1_sample, old_sample};

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !mid_st.full)
    else $error("front pushes into a full queue");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    ring_index <= LAST_IDX)
    else $error("ring index beyond the window");

endmodule

@@ rtl/pva_back.sv @@
// Back end: keeps the window sum, applies hysteresis and scales to a volume.
module pva_back #(
  parameter int unsigned WINDOW      = 30,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pva_pkg::HYST_W-1:0]   hysteresis,
  input  pva_pkg::pva_fifo_st_t        mid_st,
  input  logic [2*SAMPLE_BITS-1:0]     mid_data,
  output logic                         mid_pop,
  input  pva_pkg::pva_fifo_st_t        out_st,
  output logic                         out_push,
  output logic [pva_pkg::VOL_W-1:0]    out_data
);
  import pva_pkg::*;

  localparam int unsigned SUM_W   = $clog2(WINDOW * ((2 ** SAMPLE_BITS) - 1) + 1);
  localparam int unsigned CMP_W   = ((SUM_W > HYST_W) ? SUM_W : HYST_W) + 1;
  localparam int unsigned DIV_VAL = WINDOW * (2 ** (SAMPLE_BITS - 8));
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [SUM_W-1:0]   DIV_C = SUM_W'(DIV_VAL);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SUM_W) / DIV_VAL);

  logic                   adv;
  logic [SAMPLE_BITS-1:0] new_smp;
  logic [SAMPLE_BITS-1:0] old_smp;
  logic [SUM_W-1:0]       window_sum;
  logic [SUM_W-1:0]       applied_sum;
  logic                   a_valid;
  logic [CMP_W-1:0]       ws_x;
  logic [CMP_W-1:0]       ap_x;
  logic [CMP_W-1:0]       hy_x;
  logic                   emit;
  logic                   b_valid;
  logic [SUM_W-1:0]       b_sum;
  logic                   c_valid;
  logic [SUM_W-1:0]       c_sum;
  logic [PROD_W-1:0]      c_prod;
  logic [SUM_W-1:0]       q0;
  logic [SUM_W-1:0]       qd;
  logic [SUM_W-1:0]       rem;
  logic                   fix;
  logic [SUM_W-1:0]       rem_final;
  logic [SUM_W:0]         quot;

  // The whole pipeline holds while a finished volume cannot enter the output queue.
  assign adv     = !(c_valid && out_st.full);
  assign mid_pop = adv && !mid_st.empty;
  assign new_smp = mid_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign old_smp = mid_data[SAMPLE_BITS-1:0];

  // Hysteresis test against the sum last applied.
  assign ws_x = CMP_W'(window_sum);
  assign ap_x = CMP_W'(applied_sum);
  assign hy_x = CMP_W'(hysteresis);
  assign emit = (ws_x > ap_x + hy_x) || (ws_x + hy_x < ap_x);

  // Control state and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum  <= '0;
      applied_sum <= '0;
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
    end else if (adv) begin
      a_valid <= !mid_st.empty;
      b_valid <= a_valid && emit;
      c_valid <= b_valid;
      if (!mid_st.empty) begin
        window_sum <= window_sum - SUM_W'(old_smp) + SUM_W'(new_smp);
      end
      if (a_valid && emit) begin
        applied_sum <= window_sum;
      end
    end
  end

  // Payload stages: capture the sum, then multiply by the reciprocal.
  always_ff @(posedge clk) begin
    if (adv) begin
      b_sum  <= window_sum;
      c_sum  <= b_sum;
      c_prod <= PROD_W'(b_sum) * PROD_W'(RECIP);
    end
  end

  // Quotient estimate is low by at most one; one compare corrects it.
  assign q0        = SUM_W'(c_prod >> SUM_W);
  assign qd        = SUM_W'(q0 * DIV_C);
  assign rem       = c_sum - qd;
  assign fix       = (rem >= DIV_C);
  assign rem_final = fix ? rem - DIV_C : rem;
  assign quot      = {1'b0, q0} + (SUM_W + 1)'(fix);

  assign out_push = c_valid && !out_st.full;
  assign out_data = (quot > (SUM_W + 1)'(VOL_MAX)) ? VOL_MAX : quot[VOL_W-1:0];

  a_div_exact: assert property (@(posedge clk) disable iff (rst)
    c_valid |-> (rem_final < DIV_C))
    else $error("volume quotient off by more than one");

  a_applied_on_emit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(applied_sum)) |-> $past(adv && a_valid && emit))
    else $error("applied sum changed without an emitted beat");

endmodule

@@ rtl/pot_volume_average_hysteresis_core.sv @@
// Top level of the potentiometer volume block: moving average with hysteresis.
//
//   channel  direction  handshake             payload
//   input    in         push / full           adc_sample[SAMPLE_BITS-1:0]
//   result   out        empty / pop           volume[7:0]
//   config   in         cfg_valid / cfg_ready cfg_data[14:0] (hysteresis)
//
// One sample is accepted every cycle while full is low; the ring is a RAM
// with one write and one registered read port, so a front stage register
// holds each sample until its evicted entry is read.
// Reset clears the sums and a fill flag; unwritten ring entries read as zero,
// so no clearing pass is needed. The hysteresis register resets to 2*WINDOW.
// Stalls on the result side fill the output queue, then the middle queue, then
// raise full; cfg_ready is always high.
module pot_volume_average_hysteresis_core #(
  parameter int unsigned WINDOW      = 30,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [SAMPLE_BITS-1:0]     adc_sample,
  output logic                       empty,
  input  logic                       pop,
  output logic [pva_pkg::VOL_W-1:0]  volume,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pva_pkg::HYST_W-1:0] cfg_data
);
  import pva_pkg::*;

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;
  localparam logic [HYST_W-1:0] HYST_RESET = HYST_W'(2 * WINDOW);

  logic [HYST_W-1:0]        hysteresis;
  pva_fifo_st_t             mid_st;
  pva_fifo_st_t             out_st;
  logic                     mid_push;
  logic                     mid_pop;
  logic [2*SAMPLE_BITS-1:0] mid_wdata;
  logic [2*SAMPLE_BITS-1:0] mid_rdata;
  logic                     out_push;
  logic [VOL_W-1:0]         out_wdata;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hysteresis <= HYST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hysteresis <= cfg_data;
    end
  end

  pva_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .adc_sample (adc_sample),
    .mid_st     (mid_st),
    .mid_push   (mid_push),
    .mid_data   (mid_wdata)
  );

  pva_fifo #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .st    (mid_st)
  );

  pva_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .hysteresis (hysteresis),
    .mid_st     (mid_st),
    .mid_data   (mid_rdata),
    .mid_pop    (mid_pop),
    .out_st     (out_st),
    .out_push   (out_push),
    .out_data   (out_wdata)
  );

  pva_fifo #(
    .WIDTH (VOL_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .pop   (pop),
    .rdata (volume),
    .st    (out_st)
  );

  assign empty = out_st.empty;

endmodule

@@ tb/pva_volume_checker.sv @@
// Checker for the potentiometer volume block: predicts volumes and compares result beats.
`timescale 1ns / 100ps

module pva_volume_checker #(
  parameter int unsigned WINDOW      = 30,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       full,
  input  logic [SAMPLE_BITS-1:0]     adc_sample,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [pva_pkg::VOL_W-1:0]  volume,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [pva_pkg::HYST_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         pending,
  output int                         volumes_checked
);

  import pva_pkg::*;

  localparam int unsigned VOL_DIVISOR = WINDOW << (SAMPLE_BITS - 8);
  localparam logic [HYST_W-1:0] HYST_RESET = HYST_W'(2 * WINDOW);
  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the averaging state.
  logic [SAMPLE_BITS-1:0] pot_ring [WINDOW];
  int unsigned            ring_slot;
  int unsigned            window_total;
  int unsigned            applied_total;
  logic [HYST_W-1:0]      hyst_setting;

  // Volumes still owed by the block, oldest first. The counters start at zero.
  logic [VOL_W-1:0] volume_q [$];
  int               fail_count;
  int               checked_count;

  // Slide one reading into the window and decide whether the volume moves.
  function automatic void advance_window(input logic [SAMPLE_BITS-1:0] reading,
                                         output bit changed,
                                         output logic [VOL_W-1:0] level);
    int unsigned quotient;
    window_total = window_total - pot_ring[ring_slot] + reading;
    pot_ring[ring_slot] = reading;
    ring_slot = (ring_slot + 1 == WINDOW) ? 0 : ring_slot + 1;
    changed = (window_total > applied_total + hyst_setting) ||
              (window_total + hyst_setting < applied_total);
    level = '0;
    if (changed) begin
      quotient = window_total / VOL_DIVISOR;
      level = (quotient > VOL_MAX) ? VOL_MAX : quotient[VOL_W-1:0];
      applied_total = window_total;
    end
  endfunction

  always @(posedge clk) begin
    bit               changed;
    logic [VOL_W-1:0] level;
    logic [VOL_W-1:0] owed;
    if (rst) begin
      foreach (pot_ring[i]) pot_ring[i] = '0;
      ring_slot     = 0;
      window_total  = 0;
      applied_total = 0;
      hyst_setting  = HYST_RESET;
      volume_q.delete();
    end else begin
      // Register write; the stimulus only does this while the block is idle.
      if (cfg_valid && cfg_ready) begin
        hyst_setting = cfg_data;
      end

      // Result beat against the oldest owed volume.
      if (pop && !empty) begin
        if (volume_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: volume beat %0d arrived with none owed", $realtime, volume);
          end
        end else begin
          owed = volume_q.pop_front();
          checked_count++;
          if (volume !== owed) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: volume mismatch, expected %0d, got %0d",
                       $realtime, owed, volume);
            end
          end
        end
      end

      // Sample beat: update the window and queue a volume if it moves.
      if (push && !full) begin
        advance_window(adc_sample, changed, level);
        if (changed) begin
          volume_q.push_back(level);
        end
      end
    end
    mismatches      <= fail_count;
    pending         <= volume_q.size();
    volumes_checked <= checked_count;
  end

endmodule

@@ tb/tb_pot_volume_average_hysteresis_core.sv @@
// Top of the potentiometer volume testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_pot_volume_average_hysteresis_core;

  import pva_pkg::*;

  localparam int unsigned WINDOW      = 30;
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int          STALL_LIMIT = 4000;
  localparam int          HOLD_CYCLES = 80;
  localparam int          SETTLE_CYCLES = 10;
  localparam int unsigned READING_MAX = (1 << SAMPLE_BITS) - 1;
  localparam logic [HYST_W-1:0] HYST_MAX = 15'd30690;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {KNOB_UNIFORM, KNOB_WALK, KNOB_HOLD_LOW, KNOB_HOLD_HIGH, KNOB_RAMP}
    knob_motion_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic [SAMPLE_BITS-1:0] adc_sample = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [VOL_W-1:0]       volume;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [HYST_W-1:0]      cfg_data = '0;

  int mismatches;
  int pending;
  int volumes_checked;

  // Shared between the stimulus and the receiver.
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;

  int samples_sent    = 0;
  int settings_written = 0;
  int full_cycles     = 0;
  int quiet_cycles    = 0;

  // Knob model for the random readings.
  knob_motion_t knob_motion = KNOB_UNIFORM;
  int           motion_left = 0;
  int           knob_pos    = 0;

  pot_volume_average_hysteresis_core #(
    .WINDOW(WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .adc_sample(adc_sample),
    .empty(empty),
    .pop(pop),
    .volume(volume),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  pva_volume_checker #(
    .WINDOW(WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .adc_sample(adc_sample),
    .empty(empty),
    .pop(pop),
    .volume(volume),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .pending(pending),
    .volumes_checked(volumes_checked)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: ends the run when no beat of any kind moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && full) begin
        full_cycles <= full_cycles + 1;
      end
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $realtime, STALL_LIMIT);
        $display("FAIL pot_volume_average_hysteresis_core");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: random stalls, plus long hold-offs on request.
  initial begin : receiver
    int held;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        pop <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // Offer one reading, with random idle cycles ahead of it.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] reading);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    adc_sample <= reading;
    do @(posedge clk); while (full);
    samples_sent++;
  endtask

  // Stop offering and wait until every owed volume has come out.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hysteresis(input logic [HYST_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  function automatic void set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        pop_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 45;
        pop_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        pop_stall_pct = 45;
      end
      default: begin
        send_idle_pct = 17;
        pop_stall_pct = 17;
      end
    endcase
  endfunction

  // Next random reading: bursts of knob motion so the window sum sweeps
  // across the hysteresis band in both directions.
  function automatic logic [SAMPLE_BITS-1:0] next_reading();
    if (motion_left == 0) begin
      knob_motion = knob_motion_t'($urandom_range(KNOB_RAMP, KNOB_UNIFORM));
      motion_left = $urandom_range(40, 5);
    end
    motion_left--;
    case (knob_motion)
      KNOB_UNIFORM:   knob_pos = $urandom_range(READING_MAX);
      KNOB_HOLD_LOW:  knob_pos = $urandom_range(3);
      KNOB_HOLD_HIGH: knob_pos = READING_MAX - $urandom_range(3);
      KNOB_RAMP:      knob_pos = knob_pos + ((motion_left % 2 == 0) ? 31 : 17);
      default:        knob_pos = knob_pos + $urandom_range(80) - 40;
    endcase
    if (knob_pos < 0) knob_pos = 0;
    if (knob_pos > READING_MAX) knob_pos = READING_MAX;
    return knob_pos[SAMPLE_BITS-1:0];
  endfunction

  task automatic run_phase(input logic [HYST_W-1:0] hyst, input idle_mode_t mode,
                           input int count, input bit with_hold);
    drain();
    write_hysteresis(hyst);
    set_idle_mode(mode);
    if (with_hold) begin
      hold_requests++;
    end
    repeat (count) send_sample(next_reading());
  endtask

  initial begin : stimulus
    logic [SAMPLE_BITS-1:0] directed [$];
    directed = '{10'd60, 10'd1, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                 10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd0, 10'h2AA, 10'h155,
                 10'd512, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                 10'd0, 10'd1};
    while (rst) @(posedge clk);

    // Directed part at the reset hysteresis: a sum exactly at the band edge
    // emits nothing, one more emits, then full-scale and zero readings.
    foreach (directed[i]) send_sample(directed[i]);

    // Random phases over hysteresis extremes and every idling mode; the
    // zero-hysteresis phase opens with a long result hold-off.
    run_phase(15'd60,   IDLE_NONE,     200, 1'b0);
    run_phase(15'd0,    IDLE_NONE,     150, 1'b1);
    run_phase(HYST_MAX, IDLE_RECEIVER,  80, 1'b0);
    run_phase(15'd1,    IDLE_RECEIVER, 200, 1'b0);
    run_phase(15'd1053, IDLE_BOTH,     200, 1'b0);
    run_phase(HYST_W'($urandom_range(600)), IDLE_SENDER, 200, 1'b0);
    run_phase(HYST_W'($urandom_range(HYST_MAX)), IDLE_BOTH, 100, 1'b0);
    run_phase(15'd120,  IDLE_SENDER,   150, 1'b0);
    drain();

    $display("Run covered %0d samples and %0d volume updates over %0d hysteresis settings,",
             samples_sent, volumes_checked, settings_written);
    $display("including zero and full-scale hysteresis; input held off by full %0d cycles.",
             full_cycles);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS pot_volume_average_hysteresis_core");
    end else begin
      $display("FAIL pot_volume_average_hysteresis_core");
    end
    $finish;
  end

endmodule
